// ----- design/waveshaper_mix_overflow_macros.svh -----
// ============================================================================
// Waveshaper assertion macros
// Concurrent assertion shorthands on clk with rst as disable.
// ============================================================================
`ifndef WAVESHAPER_MIX_OVERFLOW_MACROS_SVH
`define WAVESHAPER_MIX_OVERFLOW_MACROS_SVH

// same-cycle implication
`define WSMO_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WSMO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/wsmo_pkg.sv -----
// ============================================================================
// Waveshaper package
// Command and overflow mode codes, and the shaping table control group.
// ============================================================================
package wsmo_pkg;

  localparam int PORT_BITS = 16;
  localparam int GAIN_BITS = 16;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_PROC = 1'b1;

  localparam logic [1:0] MODE_KEEP = 2'd0;
  localparam logic [1:0] MODE_SAT  = 2'd1;
  localparam logic [1:0] MODE_WRAP = 2'd2;
  localparam logic [1:0] MODE_FOLD = 2'd3;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } table_ctrl_t;

endpackage

// ----- design/waveshaper_mix_overflow.sv -----
// ============================================================================
// Waveshaper with dry/wet mix and overflow handling
// Table-driven distortion on signed audio with selectable overflow mode.
// ============================================================================
// Usage: the request channel (req_valid/req_ready) carries either a table
// load (cmd = 0: table_value stored at table_index) or a sample (cmd = 1:
// sample_in shaped and mixed by wet_gain). Every entry a sample reaches must
// be loaded first. Loads give no result; each sample gives one result on the
// response channel (rsp_valid/rsp_ready) as sample_out and was_out_of_range.
// overflow_mode is written through cfg_wen/cfg_wdata while the block is idle,
// a rule for the user that the block itself does not enforce. A sample passes
// the eight-stage pipe (table read, two multipliers, sum, rounding shift,
// range check, reciprocal multiply, remainder multiply, output select) in
// order. Throughput: one request per cycle unless the receiver stalls.
// Reset: synchronous rst empties the pipe and sets overflow_mode to
// saturate; the table keeps whatever it held and must be loaded again.
// Stall: each stage advances only when the next one is free, so a stalled
// receiver holds the output and backs the pipe up stage by stage; req_ready
// drops only when every stage holds a sample.
// ============================================================================
`include "waveshaper_mix_overflow_macros.svh"

module waveshaper_mix_overflow import wsmo_pkg::*; #(
  parameter int SAMPLE_BITS    = 16,
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic                        cmd,
  input  logic        [PORT_BITS-1:0] table_index,
  input  logic signed [PORT_BITS-1:0] table_value,
  input  logic signed [PORT_BITS-1:0] sample_in,
  input  logic signed [GAIN_BITS-1:0] wet_gain,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output logic signed [PORT_BITS-1:0] sample_out,
  output logic                        was_out_of_range,
  input  logic                        cfg_wen,
  input  logic                  [1:0] cfg_wdata
);

  localparam int S    = SAMPLE_BITS;
  localparam int F    = GAIN_FRAC_BITS;
  localparam int DW   = GAIN_BITS + 1;
  localparam int P1W  = DW + S;
  localparam int P2W  = GAIN_BITS + S;
  localparam int AW   = DW + S + 1;
  localparam int MW   = AW - F;
  localparam int UW   = MW + 1;
  localparam longint SPAN = (longint'(1) << S) - 1;
  localparam longint PER  = 2 * SPAN;
  localparam int PERW = $clog2(PER + 1);
  localparam longint OFFS = PER * (((longint'(1) << (MW - 1)) + PER - 1) / PER);
  localparam longint CU   = OFFS + (longint'(1) << (S - 1));
  localparam int KSH  = UW + $clog2(PER);
  localparam int RW   = UW + 1;
  localparam longint RCP  = ((longint'(1) << KSH) + PER - 1) / PER;
  localparam int PRW  = UW + RW;
  localparam int QW   = PRW - KSH;
  localparam int QPW  = QW + PERW;
  localparam logic signed [DW-1:0] ONE = DW'(longint'(1) << F);
  localparam logic signed [AW-1:0] RBIAS = AW'((longint'(1) << F) - 1);

  logic [1:0] mode;

  logic v_a, v_b, v_c, v_d, v_e, v_f, v_g;
  logic en_a, en_b, en_c, en_d, en_e, en_f, en_g, en_h;
  logic accept;

  logic signed [S-1:0]         x_a;
  logic signed [GAIN_BITS-1:0] g_a;
  logic        [S-1:0]         t_raw;
  logic signed [S-1:0]         t_a;
  logic signed [P1W-1:0]       prod_dry_b;
  logic signed [P2W-1:0]       prod_wet_b;
  logic signed [AW-1:0]        acc_c;
  logic signed [MW-1:0]        mixed_d;
  logic                        oor_e, oor_f, oor_g;
  logic        [S-1:0]         wrap_e, wrap_f, wrap_g;
  logic        [S-1:0]         sat_e, sat_f, sat_g;
  logic        [UW-1:0]        u_e, u_f, u_g;
  logic        [PRW-1:0]       prod_f;
  logic        [UW-1:0]        qp_g;

  table_ctrl_t                 tctrl;
  logic signed [DW-1:0]        dry_gain;
  logic signed [AW-1:0]        acc_biased;
  logic        [MW-S:0]        hi_bits;
  logic signed [MW+1:0]        u_wide;
  logic        [QW-1:0]        q;
  logic        [QPW-1:0]       qp;
  logic        [UW-1:0]        rem;
  logic        [UW-1:0]        rem_fix;
  logic        [PERW-1:0]      w;
  logic        [PERW-1:0]      fw;
  logic        [S-1:0]         fres;
  logic        [S-1:0]         res;
  logic        [S-1:0]         sat_chk;

  assign en_h = !rsp_valid || rsp_ready;
  assign en_g = !v_g || en_h;
  assign en_f = !v_f || en_g;
  assign en_e = !v_e || en_f;
  assign en_d = !v_d || en_e;
  assign en_c = !v_c || en_d;
  assign en_b = !v_b || en_c;
  assign en_a = !v_a || en_b;

  assign req_ready = en_a;
  assign accept    = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_SAT;
    end else if (cfg_wen) begin
      mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a       <= 1'b0;
      v_b       <= 1'b0;
      v_c       <= 1'b0;
      v_d       <= 1'b0;
      v_e       <= 1'b0;
      v_f       <= 1'b0;
      v_g       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (en_a) v_a <= accept && (cmd == CMD_PROC);
      if (en_b) v_b <= v_a;
      if (en_c) v_c <= v_b;
      if (en_d) v_d <= v_c;
      if (en_e) v_e <= v_d;
      if (en_f) v_f <= v_e;
      if (en_g) v_g <= v_f;
      if (en_h) rsp_valid <= v_g;
    end
  end

  // table: write on load, read whenever the first stage advances
  assign tctrl.wr_en = accept && (cmd == CMD_LOAD);
  assign tctrl.rd_en = en_a;

  wsmo_table #(
    .ADDR_BITS (S),
    .DATA_BITS (S)
  ) u_table (
    .clk   (clk),
    .ctrl  (tctrl),
    .waddr (table_index[S-1:0]),
    .wdata (table_value[S-1:0]),
    .raddr ({~sample_in[S-1], sample_in[S-2:0]}),
    .rdata (t_raw)
  );

  assign t_a        = signed'(t_raw);
  assign dry_gain   = ONE - DW'(g_a);
  assign acc_biased = acc_c + (acc_c[AW-1] ? RBIAS : AW'(0));
  assign hi_bits    = mixed_d[MW-1:S-1];
  assign u_wide     = (MW + 2)'(mixed_d) + (MW + 2)'(CU);
  assign q          = prod_f[PRW-1:KSH];
  assign qp         = QPW'(q) * QPW'(PER);

  always_ff @(posedge clk) begin
    if (en_a) begin
      x_a <= signed'(sample_in[S-1:0]);
      g_a <= wet_gain;
    end
    if (en_b) begin
      prod_dry_b <= P1W'(dry_gain) * P1W'(x_a);
      prod_wet_b <= P2W'(g_a) * P2W'(t_a);
    end
    if (en_c) begin
      acc_c <= AW'(prod_dry_b) + AW'(prod_wet_b);
    end
    if (en_d) begin
      mixed_d <= acc_biased[AW-1:F];
    end
    if (en_e) begin
      oor_e  <= !((&hi_bits) || !(|hi_bits));
      wrap_e <= mixed_d[S-1:0];
      sat_e  <= {mixed_d[MW-1], {(S - 1){~mixed_d[MW-1]}}};
      u_e    <= u_wide[UW-1:0];
    end
    if (en_f) begin
      prod_f <= PRW'(u_e) * PRW'(RCP);
      oor_f  <= oor_e;
      wrap_f <= wrap_e;
      sat_f  <= sat_e;
      u_f    <= u_e;
    end
    if (en_g) begin
      qp_g   <= qp[UW-1:0];
      oor_g  <= oor_f;
      wrap_g <= wrap_f;
      sat_g  <= sat_f;
      u_g    <= u_f;
    end
    if (en_h) begin
      sample_out       <= PORT_BITS'(signed'(res));
      was_out_of_range <= oor_g;
    end
  end

  // fold: reflect the remainder of the period back into the sample range
  always_comb begin
    rem     = u_g - qp_g;
    rem_fix = (rem >= UW'(PER)) ? rem - UW'(PER) : rem;
    w       = rem_fix[PERW-1:0];
    fw      = (w > PERW'(SPAN)) ? PERW'(PER) - w : w;
    fres    = {~fw[S-1], fw[S-2:0]};
  end

  always_comb begin
    unique case (mode)
      MODE_KEEP: res = wrap_g;
      MODE_SAT:  res = oor_g ? sat_g : wrap_g;
      MODE_WRAP: res = wrap_g;
      MODE_FOLD: res = oor_g ? fres : wrap_g;
      default:   res = wrap_g;
    endcase
  end

  assign sat_chk = {sample_out[S-1], {(S - 1){~sample_out[S-1]}}};

  `WSMO_ASSERT_NEXT(a_load_no_result, accept && (cmd == CMD_LOAD) && en_a, !v_a, "load entered pipe")
  `WSMO_ASSERT_NEXT(a_sample_enters, accept && (cmd == CMD_PROC), v_a, "sample request lost")
  `WSMO_ASSERT_SAME(a_fold_remainder, v_g, rem_fix < UW'(PER), "fold remainder out of period")
  `WSMO_ASSERT_SAME(a_sat_limit, rsp_valid && (mode == MODE_SAT) && was_out_of_range, sample_out[S-1:0] == sat_chk, "saturation not at a limit")

endmodule

// ----- design/wsmo_table.sv -----
// ============================================================================
// Shaping table
// Single-port-write, registered-read memory holding the shaping curve.
// ============================================================================
module wsmo_table import wsmo_pkg::*; #(
  parameter int ADDR_BITS = 16,
  parameter int DATA_BITS = 16
) (
  input  logic                 clk,
  input  table_ctrl_t          ctrl,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// Waveshaper mix and overflow testbench
// Loads shaping table entries, streams samples through the dry/wet mix under
// every overflow mode and checks each result against an in-bench predictor,
// with random idling on both channels and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top import wsmo_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    logic signed [PORT_BITS-1:0] sample_out;
    logic                        was_out_of_range;
  } shaped_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        req_valid = 1'b0;
  logic                        req_ready;
  logic                        cmd = CMD_LOAD;
  logic        [PORT_BITS-1:0] table_index = '0;
  logic signed [PORT_BITS-1:0] table_value = '0;
  logic signed [PORT_BITS-1:0] sample_in = '0;
  logic signed [GAIN_BITS-1:0] wet_gain = '0;
  logic                        rsp_valid;
  logic                        rsp_ready = 1'b0;
  logic signed [PORT_BITS-1:0] sample_out;
  logic                        was_out_of_range;
  logic                        cfg_wen = 1'b0;
  logic                  [1:0] cfg_wdata = MODE_SAT;

  logic signed [PORT_BITS-1:0] shape_mem [0:65535];
  bit                          loaded [0:65535];
  int unsigned                 loaded_idx[$];
  shaped_t                     expected_shaped[$];
  logic                  [1:0] mode_q = MODE_SAT;

  bit  req_idle_on = 1'b1;
  bit  rsp_idle_on = 1'b1;
  bit  hold_request = 1'b0;
  int  hold_left = 0;
  int  cycle_count = 0;
  int  errors = 0;
  int  n_loads = 0;
  int  n_samples = 0;
  int  n_checked = 0;
  int  n_oor = 0;
  bit  seen_stall = 1'b0;

  waveshaper_mix_overflow u_top (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_ready        (req_ready),
    .cmd              (cmd),
    .table_index      (table_index),
    .table_value      (table_value),
    .sample_in        (sample_in),
    .wet_gain         (wet_gain),
    .rsp_valid        (rsp_valid),
    .rsp_ready        (rsp_ready),
    .sample_out       (sample_out),
    .was_out_of_range (was_out_of_range),
    .cfg_wen          (cfg_wen),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // hold off the response side for a counted stretch when asked
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= !(rsp_idle_on && $urandom_range(99) < 10);
    end
  end

  always @(posedge clk) begin
    shaped_t want;
    if (!rst && req_valid && !req_ready)
      seen_stall = 1'b1;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_shaped.size() == 0) begin
        errors++;
        $display("%0t: unexpected result sample_out=%0d was_out_of_range=%0b",
                 $time, sample_out, was_out_of_range);
      end else begin
        want = expected_shaped.pop_front();
        n_checked++;
        if (sample_out !== want.sample_out) begin
          errors++;
          $display("%0t: sample_out expected %0d actual %0d",
                   $time, want.sample_out, sample_out);
        end
        if (was_out_of_range !== want.was_out_of_range) begin
          errors++;
          $display("%0t: was_out_of_range expected %0b actual %0b",
                   $time, want.was_out_of_range, was_out_of_range);
        end
      end
    end
  end

  function automatic shaped_t shape_and_mix(input logic signed [PORT_BITS-1:0] x,
                                            input logic signed [GAIN_BITS-1:0] g);
    shaped_t         r;
    longint signed   dry, wet, gain, acc, mixed, res, w;
    logic     [15:0] idx;
    idx   = {~x[15], x[14:0]};
    dry   = x;
    wet   = shape_mem[idx];
    gain  = g;
    acc   = (64'sd4096 - gain) * dry + gain * wet;
    mixed = acc / 64'sd4096;
    r.was_out_of_range = (mixed > 32767) || (mixed < -32768);
    case (mode_q)
      MODE_SAT: begin
        res = (mixed > 32767) ? 32767 : ((mixed < -32768) ? -32768 : mixed);
      end
      MODE_FOLD: begin
        res = mixed;
        if (r.was_out_of_range) begin
          w = (mixed + 32768) % 131070;
          if (w < 0)
            w += 131070;
          if (w > 65535)
            w = 131070 - w;
          res = w - 32768;
        end
      end
      default: begin
        res = mixed;
      end
    endcase
    r.sample_out = res[15:0];
    return r;
  endfunction

  task automatic send_request(input logic                        c,
                              input logic        [PORT_BITS-1:0] idx,
                              input logic signed [PORT_BITS-1:0] val,
                              input logic signed [PORT_BITS-1:0] smp,
                              input logic signed [GAIN_BITS-1:0] gain);
    while (req_idle_on && $urandom_range(99) < 10) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid   <= 1'b1;
    cmd         <= c;
    table_index <= idx;
    table_value <= val;
    sample_in   <= smp;
    wet_gain    <= gain;
    do
      @(posedge clk);
    while (!req_ready);
    if (c == CMD_LOAD) begin
      shape_mem[idx] = val;
      if (!loaded[idx]) begin
        loaded[idx] = 1'b1;
        loaded_idx.push_back(idx);
      end
      n_loads++;
    end else begin
      expected_shaped.push_back(shape_and_mix(smp, gain));
      if (expected_shaped[$].was_out_of_range)
        n_oor++;
      n_samples++;
    end
  endtask

  task automatic load_entry(input logic [15:0] idx, input logic signed [15:0] val);
    send_request(CMD_LOAD, idx, val, 16'($urandom), 16'($urandom));
  endtask

  task automatic process_sample(input logic signed [15:0] smp,
                                input logic signed [15:0] gain);
    send_request(CMD_PROC, 16'($urandom), 16'($urandom), smp, gain);
  endtask

  function automatic logic signed [15:0] pick_level();
    case ($urandom_range(3))
      0: return ($urandom_range(1) != 0) ? 16'sh7fff : 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_gain();
    case ($urandom_range(7))
      0, 1: return 16'($urandom);
      2: begin
        case ($urandom_range(3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sd0;
          default: return 16'sd4096;
        endcase
      end
      default: return 16'($urandom_range(4096));
    endcase
  endfunction

  task automatic send_random_item(input int load_pct);
    logic [15:0] idx;
    if (loaded_idx.size() == 0 || $urandom_range(99) < load_pct) begin
      load_entry(16'($urandom), pick_level());
    end else begin
      idx = 16'(loaded_idx[$urandom_range(loaded_idx.size() - 1)]);
      process_sample(idx ^ 16'h8000, pick_gain());
    end
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (expected_shaped.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_overflow_mode(input logic [1:0] m);
    cfg_wen   <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    mode_q = m;
  endtask

  task automatic test_saturate_edges();
    load_entry(16'h0000, 16'sh7fff);
    load_entry(16'hffff, 16'sh8000);
    load_entry(16'h8000, 16'sh8000);
    load_entry(16'h7fff, 16'sh7fff);
    process_sample(16'sh8000, 16'sd4096);
    process_sample(16'sh8000, 16'sd0);
    process_sample(16'sh7fff, 16'sh8000);
    process_sample(16'sh8000, 16'sh8000);
    process_sample(16'sd0, 16'sh7fff);
    process_sample(-16'sd1, 16'sd2048);
    wait_drained();
  endtask

  task automatic test_overflow_modes();
    logic [1:0] modes [3] = '{MODE_KEEP, MODE_WRAP, MODE_FOLD};
    foreach (modes[i]) begin
      write_overflow_mode(modes[i]);
      process_sample(16'sh7fff, 16'sh8000);
      process_sample(16'sh8000, 16'sh8000);
      process_sample(16'sd0, 16'sh7fff);
      process_sample(16'sh7fff, 16'sh7fff);
      wait_drained();
    end
  endtask

  task automatic test_random_traffic();
    logic [1:0] modes [5] = '{MODE_KEEP, MODE_FOLD, MODE_WRAP, MODE_SAT, MODE_FOLD};
    foreach (modes[i]) begin
      write_overflow_mode(modes[i]);
      req_idle_on = (i != 2);
      rsp_idle_on = (i != 2);
      repeat (150) send_random_item(i == 0 ? 50 : 25);
      wait_drained();
    end
    req_idle_on = 1'b1;
    rsp_idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    write_overflow_mode(2'($urandom_range(3)));
    req_idle_on  = 1'b0;
    hold_request = 1'b1;
    repeat (40) send_random_item(10);
    req_idle_on = 1'b1;
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_saturate_edges();
    test_overflow_modes();
    test_random_traffic();
    test_backpressure();
    $display("covered %0d table loads and %0d samples, %0d results checked, %0d out of range",
             n_loads, n_samples, n_checked, n_oor);
    $display("all four overflow modes, random idling on both sides, input stall seen: %0b",
             seen_stall);
    if (errors == 0 && expected_shaped.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/wsmo_pkg.sv
design/wsmo_table.sv
design/waveshaper_mix_overflow.sv
dv/tb_top.sv
